[design/assert_macros.svh]
// Assertion macros used by the core design file.
// Depends on nothing; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

[design/plact_pkg.sv]
// Shared widths and codes of the lane admission counter table.
// Depends on nothing.
`default_nettype none
package plact_pkg;
    localparam int FUNC_W     = 2;
    localparam int KEY_W      = 16;
    localparam int TICKET_W   = 3;
    localparam int STATUS_W   = 3;
    localparam int GIDX_W     = 3;
    localparam int TIMEOUT_W  = 31;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;

    // Request function codes
    localparam logic [FUNC_W-1:0] FN_ACQUIRE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIMEOUT = 2'd1;

    // Register reset values and substitutes for a zero write
    localparam logic [COUNT_W-1:0]   LIMIT_RESET   = 8'd4;
    localparam logic [COUNT_W-1:0]   LIMIT_ZERO    = 8'd1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd30000;
endpackage
`default_nettype wire

[design/plact_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module plact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word into the read data register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[design/per_lane_admission_counter_table_core.sv]
// Lane admission counter table: top level with request sequencer.
// Depends on plact_pkg, plact_ram and assert_macros.svh.
//
// A request (func, lane_key, ticket_index, cancel_request) is taken when
// i_in_valid and o_in_ready are high; each gives one result (status,
// granted_index, timeout_value, occupancy), taken when o_out_valid and
// i_out_ready are high. The sequencer walks the lane RAM one entry at a time,
// through a read state and a compare state per entry. A hit, or a release of
// a live lane, goes through S_READ and S_CHECK to S_DONE; a miss goes on to
// S_MISS before S_DONE (an empty table skips the walk); a cancelled acquire,
// out-of-range release or unused code goes straight to S_DONE. o_in_ready is
// high only while the sequencer is idle, and the next request can be taken in
// the same cycle in which the result appears. While the receiver stalls, one
// more request is accepted and worked, and its result waits until the output
// register frees. Configuration writes are taken only while the sequencer is
// idle; a pending write holds off a request for that cycle. Reset empties the
// table, restores the defaults and drops any pending result; no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module per_lane_admission_counter_table_core #(
    parameter int LANES    = 8,
    parameter int KEY_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [plact_pkg::FUNC_W-1:0]        i_func,
    input  wire logic [plact_pkg::KEY_W-1:0]         i_lane_key,
    input  wire logic [plact_pkg::TICKET_W-1:0]      i_ticket_index,
    input  wire logic                                i_cancel_request,
    // Result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [plact_pkg::STATUS_W-1:0]      o_status,
    output logic      [plact_pkg::GIDX_W-1:0]        o_granted_index,
    output logic      [plact_pkg::TIMEOUT_W-1:0]     o_timeout_value,
    output logic      [plact_pkg::COUNT_W-1:0]       o_occupancy,
    // Configuration channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [plact_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [plact_pkg::TIMEOUT_W-1:0]     i_cfg_data
);
    localparam int KW  = (KEY_BITS < plact_pkg::KEY_W) ? KEY_BITS : plact_pkg::KEY_W;
    localparam int IW  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int UW  = $clog2(LANES + 1);
    localparam int CW  = (UW > plact_pkg::TICKET_W) ? UW : plact_pkg::TICKET_W;
    localparam int CNW = plact_pkg::COUNT_W;
    localparam int TW  = plact_pkg::TIMEOUT_W;
    localparam int WW  = KW + CNW + TW + CNW;
    // Word layout: {key, limit, timeout, count}
    localparam int TMO_LO = CNW;
    localparam int LIM_LO = CNW + TW;
    localparam int KEY_LO = CNW + TW + CNW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_MISS,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [UW-1:0]                    r_used, n_used;
    logic [IW-1:0]                    r_idx, n_idx;
    logic [plact_pkg::FUNC_W-1:0]     r_func, n_func;
    logic [KW-1:0]                    r_key, n_key;
    logic [CNW-1:0]                   r_def_limit, n_def_limit;
    logic [TW-1:0]                    r_def_timeout, n_def_timeout;
    logic [plact_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    logic [plact_pkg::GIDX_W-1:0]     r_res_idx, n_res_idx;
    logic [TW-1:0]                    r_res_tmo, n_res_tmo;
    logic [CNW-1:0]                   r_res_occ, n_res_occ;
    logic                             r_out_valid, n_out_valid;
    logic [plact_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic [plact_pkg::GIDX_W-1:0]     r_out_idx, n_out_idx;
    logic [TW-1:0]                    r_out_tmo, n_out_tmo;
    logic [CNW-1:0]                   r_out_occ, n_out_occ;

    logic                             w_we;
    logic [IW-1:0]                    w_waddr;
    logic [WW-1:0]                    w_wdata;
    logic [WW-1:0]                    w_rdata;
    logic [KW-1:0]                    w_rd_key;
    logic [CNW-1:0]                   w_rd_limit;
    logic [TW-1:0]                    w_rd_timeout;
    logic [CNW-1:0]                   w_rd_count;

    // Lane entries: key, limit, timeout and in-flight count in one word
    plact_ram #(
        .WIDTH (WW),
        .DEPTH (LANES)
    ) u_lane_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_count   = w_rdata[TMO_LO-1:0];
    assign w_rd_timeout = w_rdata[LIM_LO-1:TMO_LO];
    assign w_rd_limit   = w_rdata[KEY_LO-1:LIM_LO];
    assign w_rd_key     = w_rdata[WW-1:KEY_LO];

    // Sequencer, table update and result staging
    always_comb begin
        n_state       = r_state;
        n_used        = r_used;
        n_idx         = r_idx;
        n_func        = r_func;
        n_key         = r_key;
        n_def_limit   = r_def_limit;
        n_def_timeout = r_def_timeout;
        n_res_status  = r_res_status;
        n_res_idx     = r_res_idx;
        n_res_tmo     = r_res_tmo;
        n_res_occ     = r_res_occ;
        n_out_valid   = r_out_valid;
        n_out_status  = r_out_status;
        n_out_idx     = r_out_idx;
        n_out_tmo     = r_out_tmo;
        n_out_occ     = r_out_occ;
        w_we          = 1'b0;
        w_waddr       = r_idx;
        w_wdata       = {r_key, w_rd_limit, w_rd_timeout, w_rd_count};

        // Take configuration writes; a zero write stores the fallback value
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                plact_pkg::CFG_DEFAULT_LIMIT: begin
                    n_def_limit = (i_cfg_data[CNW-1:0] == '0) ? plact_pkg::LIMIT_ZERO
                                                              : i_cfg_data[CNW-1:0];
                end
                plact_pkg::CFG_DEFAULT_TIMEOUT: begin
                    n_def_timeout = (i_cfg_data == '0) ? plact_pkg::TIMEOUT_RESET
                                                       : i_cfg_data;
                end
                default: begin
                end
            endcase
        end

        // Drop a result once the receiver has taken it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_func       = i_func;
                    n_key        = i_lane_key[KW-1:0];
                    n_idx        = '0;
                    n_res_status = plact_pkg::ST_IGNORED;
                    n_res_idx    = '0;
                    n_res_tmo    = '0;
                    n_res_occ    = '0;
                    case (i_func)
                        plact_pkg::FN_ACQUIRE, plact_pkg::FN_QUERY: begin
                            if (i_func == plact_pkg::FN_ACQUIRE && i_cancel_request) begin
                                n_res_status = plact_pkg::ST_CANCELLED;
                                n_state      = S_DONE;
                            end else if (r_used == '0) begin
                                n_state = S_MISS;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        plact_pkg::FN_RELEASE: begin
                            n_res_idx = i_ticket_index;
                            if (CW'(i_ticket_index) < CW'(r_used)) begin
                                n_idx   = IW'(i_ticket_index);
                                n_state = S_READ;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_func == plact_pkg::FN_RELEASE) begin
                    // Give one slot back if any is held
                    if (w_rd_count != '0) begin
                        w_we         = 1'b1;
                        w_wdata      = {w_rd_key, w_rd_limit, w_rd_timeout,
                                        w_rd_count - 1'b1};
                        n_res_status = plact_pkg::ST_OK;
                        n_res_occ    = w_rd_count - 1'b1;
                    end else begin
                        n_res_occ    = w_rd_count;
                    end
                    n_state = S_DONE;
                end else if (w_rd_key == r_key) begin
                    n_res_idx = plact_pkg::GIDX_W'(r_idx);
                    if (r_func == plact_pkg::FN_ACQUIRE) begin
                        // Admit while below the lane limit
                        if (w_rd_count < w_rd_limit) begin
                            w_we         = 1'b1;
                            w_wdata      = {w_rd_key, w_rd_limit, w_rd_timeout,
                                            w_rd_count + 1'b1};
                            n_res_status = plact_pkg::ST_OK;
                            n_res_occ    = w_rd_count + 1'b1;
                        end else begin
                            n_res_status = plact_pkg::ST_BUSY;
                            n_res_occ    = w_rd_count;
                        end
                    end else begin
                        n_res_status = plact_pkg::ST_OK;
                        n_res_tmo    = w_rd_timeout;
                        n_res_occ    = w_rd_count;
                    end
                    n_state = S_DONE;
                end else if (UW'(r_idx) + UW'(1) < r_used) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_READ;
                end else begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                if (r_used == UW'(LANES)) begin
                    n_res_status = plact_pkg::ST_FULL;
                    if (r_func == plact_pkg::FN_QUERY) begin
                        n_res_tmo = r_def_timeout;
                    end
                end else begin
                    // Create the lane at the next free entry
                    w_we         = 1'b1;
                    w_waddr      = IW'(r_used);
                    n_used       = r_used + 1'b1;
                    n_res_idx    = plact_pkg::GIDX_W'(r_used);
                    n_res_status = plact_pkg::ST_OK;
                    if (r_func == plact_pkg::FN_ACQUIRE) begin
                        w_wdata   = {r_key, r_def_limit, r_def_timeout, CNW'(1)};
                        n_res_occ = CNW'(1);
                    end else begin
                        w_wdata   = {r_key, r_def_limit, r_def_timeout, CNW'(0)};
                        n_res_tmo = r_def_timeout;
                    end
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // Hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = r_res_idx;
                    n_out_tmo    = r_res_tmo;
                    n_out_occ    = r_res_occ;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, table fill count, defaults, request, staged result and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_used        <= '0;
            r_def_limit   <= plact_pkg::LIMIT_RESET;
            r_def_timeout <= plact_pkg::TIMEOUT_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_used        <= n_used;
            r_def_limit   <= n_def_limit;
            r_def_timeout <= n_def_timeout;
            r_out_valid   <= n_out_valid;
            r_idx         <= n_idx;
            r_func        <= n_func;
            r_key         <= n_key;
            r_res_status  <= n_res_status;
            r_res_idx     <= n_res_idx;
            r_res_tmo     <= n_res_tmo;
            r_res_occ     <= n_res_occ;
            r_out_status  <= n_out_status;
            r_out_idx     <= n_out_idx;
            r_out_tmo     <= n_out_tmo;
            r_out_occ     <= n_out_occ;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_index = r_out_idx;
    assign o_timeout_value = r_out_tmo;
    assign o_occupancy     = r_out_occ;

    `ASSERT_RST(a_used_bound, i_clk, i_rst_n, r_used <= UW'(LANES), "lane count above table size")
    `ASSERT_RST(a_used_step, i_clk, i_rst_n, (r_used != $past(r_used)) |-> (r_used == UW'($past(r_used) + 1'b1)), "lane count moved by more than one")
    `ASSERT_ALL(a_write_state, i_clk, w_we |-> (r_state == S_CHECK || r_state == S_MISS), "lane RAM written outside update states")
    `ASSERT_RST(a_cancel_empty, i_clk, i_rst_n, (o_out_valid && o_status == plact_pkg::ST_CANCELLED) |-> (o_occupancy == '0 && o_granted_index == '0 && o_timeout_value == '0), "cancelled result carries lane data")
endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for per_lane_admission_counter_table_core.
// Depends on plact_pkg and the core RTL; the lane table is predicted in place.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import plact_pkg::*;

    localparam int LANES = 8;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [KEY_W-1:0]    key;
        logic [TICKET_W-1:0] ticket;
        logic                cancel;
    } lane_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [GIDX_W-1:0]    gidx;
        logic [TIMEOUT_W-1:0] tmo;
        logic [COUNT_W-1:0]   occ;
    } lane_rsp_t;

    // DUT signals
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [FUNC_W-1:0]    i_func = '0;
    logic [KEY_W-1:0]     i_lane_key = '0;
    logic [TICKET_W-1:0]  i_ticket_index = '0;
    logic                 i_cancel_request = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [GIDX_W-1:0]    o_granted_index;
    logic [TIMEOUT_W-1:0] o_timeout_value;
    logic [COUNT_W-1:0]   o_occupancy;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TIMEOUT_W-1:0] i_cfg_data = '0;

    per_lane_admission_counter_table_core #(
        .LANES    (LANES),
        .KEY_BITS (KEY_W)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_lane_key       (i_lane_key),
        .i_ticket_index   (i_ticket_index),
        .i_cancel_request (i_cancel_request),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_granted_index  (o_granted_index),
        .o_timeout_value  (o_timeout_value),
        .o_occupancy      (o_occupancy),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock: 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predicted lane table and defaults
    logic [KEY_W-1:0]     lane_key_q [LANES];
    logic [COUNT_W-1:0]   lane_limit [LANES];
    logic [TIMEOUT_W-1:0] lane_tmo   [LANES];
    logic [COUNT_W-1:0]   lane_busy  [LANES];
    int                   lanes_used = 0;
    logic [COUNT_W-1:0]   dflt_limit = LIMIT_RESET;
    logic [TIMEOUT_W-1:0] dflt_timeout = TIMEOUT_RESET;

    lane_req_t   pending_reqs [$];
    lane_rsp_t   awaited_results [$];
    logic [KEY_W-1:0] lane_pool [LANES];
    int          errors = 0;
    int unsigned cycle_no = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic        quiet;

    assign quiet = (cycle_no >= 12000) && (cycle_no < 18000);

    // Look up a lane by key, open a new one if absent; -1 when the table is full
    function automatic int find_or_open_lane(input logic [KEY_W-1:0] key);
        for (int i = 0; i < lanes_used; i++) begin
            if (lane_key_q[i] == key) return i;
        end
        if (lanes_used >= LANES) return -1;
        lane_key_q[lanes_used] = key;
        lane_limit[lanes_used] = dflt_limit;
        lane_tmo[lanes_used]   = dflt_timeout;
        lane_busy[lanes_used]  = '0;
        lanes_used++;
        return lanes_used - 1;
    endfunction

    // Compute the result of one request and advance the lane table
    function automatic lane_rsp_t predict_admission(input lane_req_t rq);
        lane_rsp_t rsp;
        int        lane;
        rsp = '{status: ST_IGNORED, gidx: '0, tmo: '0, occ: '0};
        case (rq.func)
            FN_ACQUIRE: begin
                if (rq.cancel) begin
                    rsp.status = ST_CANCELLED;
                end else begin
                    lane = find_or_open_lane(rq.key);
                    if (lane < 0) begin
                        rsp.status = ST_FULL;
                    end else begin
                        rsp.gidx = GIDX_W'(lane);
                        if (lane_busy[lane] < lane_limit[lane]) begin
                            lane_busy[lane] = lane_busy[lane] + 1'b1;
                            rsp.status = ST_OK;
                        end else begin
                            rsp.status = ST_BUSY;
                        end
                        rsp.occ = lane_busy[lane];
                    end
                end
            end
            FN_RELEASE: begin
                rsp.gidx = rq.ticket;
                if (int'(rq.ticket) < lanes_used) begin
                    if (lane_busy[rq.ticket] != 0) begin
                        lane_busy[rq.ticket] = lane_busy[rq.ticket] - 1'b1;
                        rsp.status = ST_OK;
                    end
                    rsp.occ = lane_busy[rq.ticket];
                end
            end
            FN_QUERY: begin
                lane = find_or_open_lane(rq.key);
                if (lane < 0) begin
                    rsp.status = ST_FULL;
                    rsp.tmo = dflt_timeout;
                end else begin
                    rsp.status = ST_OK;
                    rsp.gidx = GIDX_W'(lane);
                    rsp.tmo = lane_tmo[lane];
                    rsp.occ = lane_busy[lane];
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Cycle counter for the idle windows
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    // Request driver: offer queued requests, predict each one accepted
    always @(posedge i_clk) begin : req_driver
        lane_req_t nxt_req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_results.push_back(predict_admission(
                    '{func: i_func, key: i_lane_key, ticket: i_ticket_index,
                      cancel: i_cancel_request}));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 36)) begin
                    nxt_req = pending_reqs.pop_front();
                    i_func           <= nxt_req.func;
                    i_lane_key       <= nxt_req.key;
                    i_ticket_index   <= nxt_req.ticket;
                    i_cancel_request <= nxt_req.cancel;
                    i_in_valid       <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off once a deep backlog is queued
    always @(posedge i_clk) begin
        if (!hold_done && pending_reqs.size() > 50) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare against the oldest prediction, drive ready
    always @(posedge i_clk) begin : rsp_monitor
        lane_rsp_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none actual status %0d",
                             $time, o_status);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("granted_index", want.gidx, o_granted_index);
                    check_field("timeout_value", want.tmo, o_timeout_value);
                    check_field("occupancy", want.occ, o_occupancy);
                end
            end
            i_out_ready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 36);
        end
    end

    task automatic push_req(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                            input logic [TICKET_W-1:0] tk, input logic cn);
        pending_reqs.push_back('{func: fn, key: key, ticket: tk, cancel: cn});
    endtask

    // Wait until every queued request has been taken and answered
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || awaited_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [TIMEOUT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DEFAULT_LIMIT)
            dflt_limit = (data[COUNT_W-1:0] == 0) ? LIMIT_ZERO : data[COUNT_W-1:0];
        else if (idx == CFG_DEFAULT_TIMEOUT)
            dflt_timeout = (data == 0) ? TIMEOUT_RESET : data;
    endtask

    // Mostly acquire/release runs on known lanes, plus queries and noise
    task automatic gen_random(input int count);
        int made, r, k, n, m;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, LANES - 1);
            if (r < 65) begin
                n = $urandom_range(1, 6);
                m = $urandom_range(n - 1, n + 1);
                repeat (n) push_req(FN_ACQUIRE, lane_pool[k], TICKET_W'($urandom),
                                    $urandom_range(0, 19) == 0);
                repeat (m) push_req(FN_RELEASE, KEY_W'($urandom), TICKET_W'(k),
                                    1'($urandom));
                made += n + m;
            end else if (r < 78) begin
                push_req(FN_QUERY, lane_pool[k], TICKET_W'($urandom), 1'($urandom));
                made++;
            end else if (r < 90) begin
                push_req(FUNC_W'($urandom), KEY_W'($urandom), TICKET_W'($urandom),
                         1'($urandom));
                made++;
            end else begin
                push_req(FN_RELEASE, KEY_W'($urandom), TICKET_W'($urandom), 1'($urandom));
                made++;
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        lane_pool[0] = '0;
        lane_pool[1] = '1;
        for (int i = 2; i < LANES; i++)
            lane_pool[i] = KEY_W'(16'h1000 * i + $urandom_range(0, 16'h0fff));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: empty table, cancel, busy, bad releases, unused code
        push_req(FN_RELEASE, '0, 3'd0, 1'b0);
        push_req(FN_QUERY, lane_pool[0], 3'd0, 1'b0);
        push_req(FN_ACQUIRE, lane_pool[1], 3'd7, 1'b1);
        repeat (5) push_req(FN_ACQUIRE, lane_pool[0], 3'd0, 1'b0);
        push_req(FN_RELEASE, '0, 3'd0, 1'b0);
        push_req(FN_RELEASE, '1, 3'd7, 1'b1);
        push_req(FN_UNUSED, '1, 3'd7, 1'b1);
        push_req(FN_ACQUIRE, lane_pool[1], 3'd7, 1'b0);
        wait_drained();

        // Zero limit write becomes one; largest timeout
        write_reg(CFG_DEFAULT_LIMIT, 31'h7fff_ff00);
        write_reg(CFG_DEFAULT_TIMEOUT, 31'h7fff_ffff);
        push_req(FN_ACQUIRE, lane_pool[2], 3'd0, 1'b0);
        push_req(FN_ACQUIRE, lane_pool[2], 3'd0, 1'b0);
        push_req(FN_RELEASE, '0, 3'd2, 1'b0);
        push_req(FN_RELEASE, '0, 3'd2, 1'b0);
        wait_drained();

        // Open the remaining lanes under different defaults
        for (int k = 3; k < LANES; k++) begin
            if (k == 3) begin
                write_reg(CFG_DEFAULT_LIMIT, 31'd255);
                write_reg(CFG_DEFAULT_TIMEOUT, 31'd1);
            end else if (k == 4) begin
                write_reg(CFG_DEFAULT_LIMIT, {23'($urandom), 8'd0});
                write_reg(CFG_DEFAULT_TIMEOUT, '0);
                write_reg(CFG_UNUSED, TIMEOUT_W'($urandom));
            end else begin
                write_reg(CFG_DEFAULT_LIMIT, TIMEOUT_W'($urandom_range(1, 8)));
                write_reg(CFG_DEFAULT_TIMEOUT, TIMEOUT_W'($urandom));
            end
            push_req(FN_QUERY, lane_pool[k], TICKET_W'(k), 1'b0);
            push_req(FN_ACQUIRE, lane_pool[k], TICKET_W'(k), 1'b0);
            wait_drained();
        end

        // Table full: new key on acquire and query
        push_req(FN_ACQUIRE, 16'h8765, 3'd0, 1'b0);
        push_req(FN_QUERY, 16'h8765, 3'd0, 1'b0);

        // Fill the wide lane to its limit and drain it again
        repeat (257) push_req(FN_ACQUIRE, lane_pool[3], 3'd0, 1'b0);
        repeat (257) push_req(FN_RELEASE, '0, 3'd3, 1'b0);
        wait_drained();

        write_reg(CFG_DEFAULT_TIMEOUT, TIMEOUT_W'($urandom));
        write_reg(CFG_DEFAULT_LIMIT, TIMEOUT_W'($urandom));
        gen_random(230);
        wait_drained();
        write_reg(CFG_DEFAULT_TIMEOUT, 31'h7fff_ffff);
        gen_random(230);
        wait_drained();
        write_reg(CFG_DEFAULT_TIMEOUT, 31'd1);
        write_reg(CFG_DEFAULT_LIMIT, 31'd255);
        gen_random(230);
        wait_drained();

        // Let any stray result show up before the verdict
        repeat (24) @(negedge i_clk);
        if (errors == 0) begin
            $display("** per_lane_admission_counter_table_core: PASSED **");
        end else begin
            $display("** per_lane_admission_counter_table_core: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("** per_lane_admission_counter_table_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
